// ===== design/differential_pump_controller_core_defines.svh =====
// Assertion macros shared by the differential pump controller RTL.
`ifndef DIFFERENTIAL_PUMP_CONTROLLER_CORE_DEFINES_SVH
`define DIFFERENTIAL_PUMP_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/dpc_pkg.sv =====
// Shared types and constants of the differential pump controller.
package dpc_pkg;

    localparam int TIME_BITS     = 32;
    localparam int MODE_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [MODE_BITS-1:0] MODE_MANUAL_ON = 8'd1;
    localparam logic [MODE_BITS-1:0] MODE_AUTO      = 8'd2;

    localparam int                   RST_SETPOINT   = 560;
    localparam int                   RST_DIFF_ON    = 160;
    localparam int                   RST_DIFF_OFF   = 80;
    localparam logic [TIME_BITS-1:0] RST_MIN_ON_MS  = 32'd60000;
    localparam logic [TIME_BITS-1:0] RST_MIN_OFF_MS = 32'd300000;
    localparam logic [TIME_BITS-1:0] RST_MAX_ON_MS  = 32'd900000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PUMP_MODE     = 3'd0,
        CFG_POOL_SETPOINT = 3'd1,
        CFG_DIFF_ON       = 3'd2,
        CFG_DIFF_OFF      = 3'd3,
        CFG_MIN_ON_MS     = 3'd4,
        CFG_MIN_OFF_MS    = 3'd5,
        CFG_MAX_ON_MS     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_ON   = 2'd1,
        ACT_OFF  = 2'd2
    } t_action;

    typedef struct packed {
        logic [MODE_BITS-1:0] pump_mode;
        logic [TIME_BITS-1:0] min_on_ms;
        logic [TIME_BITS-1:0] min_off_ms;
        logic [TIME_BITS-1:0] max_on_ms;
    } t_timing;

endpackage

// ===== design/dpc_in_if.sv =====
// Sample channel: pool and collector temperature with a timestamp.
interface dpc_in_if
    import dpc_pkg::*;
#(
    parameter int TEMP_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [TEMP_BITS-1:0] pool_temp;
    logic signed [TEMP_BITS-1:0] collector_temp;
    logic [TIME_BITS-1:0]        now_ms;

    modport source (output valid, output pool_temp, output collector_temp,
                    output now_ms, input ready);
    modport sink (input valid, input pool_temp, input collector_temp,
                  input now_ms, output ready);
endinterface

// ===== design/dpc_out_if.sv =====
// Result channel: pump drive and change flag.
interface dpc_out_if;
    logic valid;
    logic ready;
    logic pump_on;
    logic state_changed;

    modport source (output valid, output pump_on, output state_changed, input ready);
    modport sink (input valid, input pump_on, input state_changed, output ready);
endinterface

// ===== design/differential_pump_controller_core.sv =====
// Differential temperature controller for a solar pool pump.
// Samples (pool temperature, collector temperature, millisecond time) arrive
// as beats on i_sample; for every sample one beat leaves on o_result with the
// pump drive after that sample and a flag that says whether it changed.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the
// user must write it only while no sample is in flight, which the block does
// not enforce. Indices 0..6 select mode, setpoint, on and off differences,
// and the minimum-on, minimum-off and maximum-on times.
// An accepted sample passes through the sample register, where the decision
// logic and the pump state update take place, then the result register. One
// sample is taken every cycle while the receiver does not stall; the sample
// register's decision path (a 32-bit time subtract and compare) sets the clock
// period. Reset clears the pump to off, both timestamps to zero and the
// registers to their defaults. When the receiver stalls, the result beat
// holds and the sample register can still fill; then i_sample.ready drops
// until the result is taken.
`include "differential_pump_controller_core_defines.svh"

module differential_pump_controller_core
    import dpc_pkg::*;
#(
    parameter int TEMP_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    dpc_in_if.sink                   i_sample,
    dpc_out_if.source                o_result,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_timing                     timing;
    logic signed [TEMP_BITS-1:0] setpoint;
    logic signed [TEMP_BITS-1:0] diff_on;
    logic signed [TEMP_BITS-1:0] diff_off;

    logic                        r_in_valid;
    logic signed [TEMP_BITS-1:0] r_pool;
    logic signed [TEMP_BITS-1:0] r_coll;
    logic [TIME_BITS-1:0]        r_now;

    logic r_out_valid;
    logic r_pump_on;
    logic r_changed;

    logic in_fire;
    logic advance;
    logic n_pump_on;
    logic n_changed;
    logic running;

    dpc_cfg #(
        .TEMP_BITS (TEMP_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_we),
        .i_idx      (i_cfg_idx),
        .i_wdata    (i_cfg_wdata),
        .o_timing   (timing),
        .o_setpoint (setpoint),
        .o_diff_on  (diff_on),
        .o_diff_off (diff_off)
    );

    dpc_ctrl #(
        .TEMP_BITS (TEMP_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_pool     (r_pool),
        .i_coll     (r_coll),
        .i_now      (r_now),
        .i_timing   (timing),
        .i_setpoint (setpoint),
        .i_diff_on  (diff_on),
        .i_diff_off (diff_off),
        .o_pump_on  (n_pump_on),
        .o_changed  (n_changed),
        .o_running  (running)
    );

    // A held sample moves on whenever the result register is free or emptying.
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign in_fire        = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pool <= i_sample.pool_temp;
            r_coll <= i_sample.collector_temp;
            r_now  <= i_sample.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pump_on <= n_pump_on;
            r_changed <= n_changed;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.pump_on       = r_pump_on;
    assign o_result.state_changed = r_changed;

    `DPC_ASSERT_NEXT(a_advance_fills_result, advance, r_out_valid)
    `DPC_ASSERT_NEXT(a_result_matches_state, advance, r_pump_on == running)
    `DPC_ASSERT_IMPL(a_empty_takes_sample, !r_in_valid, i_sample.ready)
    `DPC_ASSERT_NEXT(a_change_follows_state, advance, r_changed == (running != $past(running)))

endmodule

// ===== design/dpc_cfg.sv =====
// Configuration register file of the differential pump controller.
module dpc_cfg
    import dpc_pkg::*;
#(
    parameter int TEMP_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [CFG_IDX_BITS-1:0]     i_idx,
    input  logic [CFG_DATA_BITS-1:0]    i_wdata,
    output t_timing                     o_timing,
    output logic signed [TEMP_BITS-1:0] o_setpoint,
    output logic signed [TEMP_BITS-1:0] o_diff_on,
    output logic signed [TEMP_BITS-1:0] o_diff_off
);

    t_timing                     r_timing;
    logic signed [TEMP_BITS-1:0] r_setpoint;
    logic signed [TEMP_BITS-1:0] r_diff_on;
    logic signed [TEMP_BITS-1:0] r_diff_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.pump_mode  <= '0;
            r_timing.min_on_ms  <= RST_MIN_ON_MS;
            r_timing.min_off_ms <= RST_MIN_OFF_MS;
            r_timing.max_on_ms  <= RST_MAX_ON_MS;
            r_setpoint          <= TEMP_BITS'(RST_SETPOINT);
            r_diff_on           <= TEMP_BITS'(RST_DIFF_ON);
            r_diff_off          <= TEMP_BITS'(RST_DIFF_OFF);
        end else if (i_we) begin
            // Index seven is not a register; such writes are dropped.
            unique case (t_cfg_idx'(i_idx))
                CFG_PUMP_MODE:     r_timing.pump_mode  <= i_wdata[MODE_BITS-1:0];
                CFG_POOL_SETPOINT: r_setpoint          <= i_wdata[TEMP_BITS-1:0];
                CFG_DIFF_ON:       r_diff_on           <= i_wdata[TEMP_BITS-1:0];
                CFG_DIFF_OFF:      r_diff_off          <= i_wdata[TEMP_BITS-1:0];
                CFG_MIN_ON_MS:     r_timing.min_on_ms  <= i_wdata[TIME_BITS-1:0];
                CFG_MIN_OFF_MS:    r_timing.min_off_ms <= i_wdata[TIME_BITS-1:0];
                CFG_MAX_ON_MS:     r_timing.max_on_ms  <= i_wdata[TIME_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_timing   = r_timing;
    assign o_setpoint = r_setpoint;
    assign o_diff_on  = r_diff_on;
    assign o_diff_off = r_diff_off;

endmodule

// ===== design/dpc_ctrl.sv =====
// Pump decision logic and the pump state with its timestamps.
module dpc_ctrl
    import dpc_pkg::*;
#(
    parameter int TEMP_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic signed [TEMP_BITS-1:0] i_pool,
    input  logic signed [TEMP_BITS-1:0] i_coll,
    input  logic [TIME_BITS-1:0]        i_now,
    input  t_timing                     i_timing,
    input  logic signed [TEMP_BITS-1:0] i_setpoint,
    input  logic signed [TEMP_BITS-1:0] i_diff_on,
    input  logic signed [TEMP_BITS-1:0] i_diff_off,
    output logic                        o_pump_on,
    output logic                        o_changed,
    output logic                        o_running
);

    logic                 r_running;
    logic [TIME_BITS-1:0] r_last_action;
    logic [TIME_BITS-1:0] r_switched_on;

    logic signed [TEMP_BITS:0] dif;
    logic                      want_on;
    logic                      want_off;
    logic [TIME_BITS-1:0]      on_elapsed;
    logic [TIME_BITS-1:0]      act_elapsed;
    t_action                   action;

    // The difference carries one extra bit so that it never wraps.
    assign dif = {i_coll[TEMP_BITS-1], i_coll} - {i_pool[TEMP_BITS-1], i_pool};
    assign want_on  = (dif >= $signed({i_diff_on[TEMP_BITS-1], i_diff_on}))
                      && (i_pool < i_setpoint);
    assign want_off = (dif <= $signed({i_diff_off[TEMP_BITS-1], i_diff_off}))
                      || (i_pool >= i_setpoint);
    assign on_elapsed  = i_now - r_switched_on;
    assign act_elapsed = i_now - r_last_action;

    always_comb begin
        action = ACT_HOLD;
        if (i_timing.pump_mode == MODE_MANUAL_ON) begin
            if (!r_running) begin
                action = ACT_ON;
            end
        end else if (i_timing.pump_mode == MODE_AUTO) begin
            priority if (r_running && on_elapsed >= i_timing.max_on_ms) begin
                action = ACT_OFF;
            end else if (!r_running && want_on && act_elapsed < i_timing.min_off_ms) begin
                action = ACT_HOLD;
            end else if (r_running && want_off && on_elapsed < i_timing.min_on_ms) begin
                action = ACT_HOLD;
            end else if (want_on && !r_running) begin
                action = ACT_ON;
            end else if (want_off && r_running) begin
                action = ACT_OFF;
            end else begin
                action = ACT_HOLD;
            end
        end else begin
            if (r_running) begin
                action = ACT_OFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_last_action <= '0;
            r_switched_on <= '0;
        end else if (i_step) begin
            unique case (action)
                ACT_ON: begin
                    r_running     <= 1'b1;
                    r_last_action <= i_now;
                    r_switched_on <= i_now;
                end
                ACT_OFF: begin
                    r_running     <= 1'b0;
                    r_last_action <= i_now;
                end
                default: begin
                end
            endcase
        end
    end

    // A switch only ever happens from the opposite state, so any action is a change.
    assign o_pump_on = (action == ACT_ON) ? 1'b1 : ((action == ACT_OFF) ? 1'b0 : r_running);
    assign o_changed = (action != ACT_HOLD);
    assign o_running = r_running;

endmodule

// ===== tb/sv/differential_pump_controller_core_tb.sv =====
// Testbench for the differential pump controller: directed table, random phases, self-check.
module differential_pump_controller_core_tb;
    import dpc_pkg::*;

    localparam int TEMP_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int PHASES = 12;
    localparam int PHASE_BEATS = 67;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic pump_on;
        logic state_changed;
    } t_pump_result;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;
    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY} t_stall;

    typedef struct packed {
        t_row_kind                 kind;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [31:0]               word;
        logic [TEMP_BITS-1:0]      pool;
        logic [TEMP_BITS-1:0]      coll;
        logic                      typed;
        logic                      exp_on;
        logic                      exp_chg;
    } t_row;

    localparam int ROWS = 34;

    // Sample rows carry the timestamp in word; write rows carry the register data.
    t_row directed_rows [ROWS] = '{
        '{ROW_SAMPLE, '0, 32'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_PUMP_MODE, {24'hFFFFFF, MODE_MANUAL_ON}, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd100, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b1},
        '{ROW_SAMPLE, '0, 32'd200, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b0},
        '{ROW_WRITE, CFG_PUMP_MODE, 32'h0000_00FF, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd300, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1},
        '{ROW_SAMPLE, '0, 32'd400, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_PUMP_MODE, {24'h000000, MODE_AUTO}, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd1000, 16'h0190, 16'h0258, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd400000, 16'h0190, 16'h0258, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd410000, 16'h0190, 16'h01C2, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd470000, 16'h0190, 16'h01C2, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'hFFFF_FF00, 16'h0190, 16'h0258, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'h000D_BAA0, 16'h0190, 16'h0258, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'h000D_BAA1, 16'h0190, 16'h0258, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_MIN_OFF_MS, 32'd0, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_MIN_ON_MS, 32'd0, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_DIFF_ON, 32'h0000_8000, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_DIFF_OFF, 32'hABCD_7FFF, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd10, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd11, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd12, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_MAX_ON_MS, 32'd0, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd13, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd14, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_IDX_SPARE, 32'h0000_0001, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_POOL_SETPOINT, 32'h0000_8000, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd15, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd16, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_POOL_SETPOINT, 32'h1234_7FFF, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE, CFG_MAX_ON_MS, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd17, 16'h7FFE, 16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, 32'd18, 16'h7FFE, 16'h7FFF, 1'b0, 1'b0, 1'b0}
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    dpc_in_if #(.TEMP_BITS(TEMP_BITS)) sample_if ();
    dpc_out_if result_if ();

    differential_pump_controller_core #(.TEMP_BITS(TEMP_BITS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Controller settings and pump state as the block should hold them.
    logic [MODE_BITS-1:0]        mode_q        = '0;
    logic signed [TEMP_BITS-1:0] setpoint_q    = TEMP_BITS'(RST_SETPOINT);
    logic signed [TEMP_BITS-1:0] diff_on_q     = TEMP_BITS'(RST_DIFF_ON);
    logic signed [TEMP_BITS-1:0] diff_off_q    = TEMP_BITS'(RST_DIFF_OFF);
    logic [TIME_BITS-1:0]        min_on_q      = RST_MIN_ON_MS;
    logic [TIME_BITS-1:0]        min_off_q     = RST_MIN_OFF_MS;
    logic [TIME_BITS-1:0]        max_on_q      = RST_MAX_ON_MS;
    logic                        running_q     = 1'b0;
    logic [TIME_BITS-1:0]        last_action_q = '0;
    logic [TIME_BITS-1:0]        on_since_q    = '0;

    t_pump_result pending_results [$];
    int           mismatches = 0;

    function automatic t_pump_result next_pump_state(input logic signed [TEMP_BITS-1:0] pool,
                                                     input logic signed [TEMP_BITS-1:0] coll,
                                                     input logic [TIME_BITS-1:0] now);
        int                   dif;
        logic                 want_on;
        logic                 want_off;
        logic                 go_on;
        logic                 go_off;
        logic                 was_on;
        logic [TIME_BITS-1:0] on_for;
        logic [TIME_BITS-1:0] idle_for;
        t_pump_result         res;
        // The difference is taken in 32 bits, so it never wraps.
        dif      = int'(coll) - int'(pool);
        want_on  = (dif >= int'(diff_on_q)) && (pool < setpoint_q);
        want_off = (dif <= int'(diff_off_q)) || (pool >= setpoint_q);
        on_for   = now - on_since_q;
        idle_for = now - last_action_q;
        was_on   = running_q;
        go_on    = 1'b0;
        go_off   = 1'b0;
        if (mode_q == MODE_MANUAL_ON) begin
            go_on = !running_q;
        end else if (mode_q == MODE_AUTO) begin
            if (running_q && on_for >= max_on_q) begin
                go_off = 1'b1;
            end else if (!(!running_q && want_on && idle_for < min_off_q) &&
                         !(running_q && want_off && on_for < min_on_q)) begin
                go_on  = want_on && !running_q;
                go_off = want_off && running_q && !go_on;
            end
        end else begin
            go_off = running_q;
        end
        if (go_on) begin
            running_q     = 1'b1;
            last_action_q = now;
            on_since_q    = now;
        end
        if (go_off) begin
            running_q     = 1'b0;
            last_action_q = now;
        end
        res.pump_on       = running_q;
        res.state_changed = running_q != was_on;
        return res;
    endfunction

    function automatic logic [TEMP_BITS-1:0] pick_extreme_temp();
        case ($urandom_range(0, 2))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return TEMP_BITS'($urandom());
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PUMP_MODE:     mode_q     = data[MODE_BITS-1:0];
            CFG_POOL_SETPOINT: setpoint_q = data[TEMP_BITS-1:0];
            CFG_DIFF_ON:       diff_on_q  = data[TEMP_BITS-1:0];
            CFG_DIFF_OFF:      diff_off_q = data[TEMP_BITS-1:0];
            CFG_MIN_ON_MS:     min_on_q   = data;
            CFG_MIN_OFF_MS:    min_off_q  = data;
            CFG_MAX_ON_MS:     max_on_q   = data;
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic signed [TEMP_BITS-1:0] pool,
                               input logic signed [TEMP_BITS-1:0] coll,
                               input logic [TIME_BITS-1:0] now,
                               input logic typed, input t_pump_result typed_exp);
        t_pump_result predicted;
        @(negedge i_clk);
        sample_if.valid          <= 1'b1;
        sample_if.pool_temp      <= pool;
        sample_if.collector_temp <= coll;
        sample_if.now_ms         <= now;
        do @(posedge i_clk); while (!sample_if.ready);
        predicted = next_pump_state(pool, coll, now);
        pending_results.push_back(typed ? typed_exp : predicted);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            sample_if.valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        sample_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("[differential_pump_controller_core] ERROR");
        $finish;
    end

    // Receiver: ready follows segments of no stall, random stall and heavy stall.
    initial begin : receiver
        t_stall style;
        int     seg_left;
        result_if.ready = 1'b0;
        seg_left = 0;
        style    = STALL_NONE;
        forever begin
            @(negedge i_clk);
            if (seg_left == 0) begin
                style    = t_stall'($urandom_range(0, 2));
                seg_left = $urandom_range(4, 40);
            end
            seg_left--;
            case (style)
                STALL_NONE:   result_if.ready <= 1'b1;
                STALL_RANDOM: result_if.ready <= 1'($urandom_range(0, 1));
                default:      result_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_beat
        t_pump_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected: pump_on %0b state_changed %0b",
                         $time, result_if.pump_on, result_if.state_changed);
            end else begin
                want = pending_results.pop_front();
                if (result_if.pump_on !== want.pump_on) begin
                    mismatches++;
                    $display("%0t: pump_on expected %0b actual %0b",
                             $time, want.pump_on, result_if.pump_on);
                end
                if (result_if.state_changed !== want.state_changed) begin
                    mismatches++;
                    $display("%0t: state_changed expected %0b actual %0b",
                             $time, want.state_changed, result_if.state_changed);
                end
            end
        end
    end

    initial begin : stimulus
        t_row                        row;
        t_pump_result                typed_exp;
        logic [31:0]                 cfg_word [7];
        logic [31:0]                 noise;
        logic [TIME_BITS-1:0]        now;
        logic [TIME_BITS-1:0]        step_max;
        logic signed [TEMP_BITS-1:0] pool;
        logic signed [TEMP_BITS-1:0] coll;
        logic [MODE_BITS-1:0]        mode_byte;
        int                          pool_i;
        int                          coll_i;
        int                          thr;
        int                          burst_left;

        sample_if.valid          = 1'b0;
        sample_if.pool_temp      = '0;
        sample_if.collector_temp = '0;
        sample_if.now_ms         = '0;
        cfg_we                   = 1'b0;
        cfg_idx                  = '0;
        cfg_wdata                = '0;
        i_rst_n                  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE) begin
                drain_results();
                write_register(row.idx, row.word);
            end else begin
                typed_exp.pump_on       = row.exp_on;
                typed_exp.state_changed = row.exp_chg;
                send_sample(row.pool, row.coll, row.word, row.typed, typed_exp);
                idle_gap($urandom_range(0, 2));
            end
        end

        now        = '0;
        burst_left = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();

            case (ph)
                1, 9:    mode_byte = MODE_MANUAL_ON;
                4:       mode_byte = '0;
                7:       mode_byte = MODE_BITS'($urandom());
                default: mode_byte = MODE_AUTO;
            endcase
            noise = $urandom();
            cfg_word[CFG_PUMP_MODE] = {noise[31:MODE_BITS], mode_byte};

            noise = $urandom();
            if (ph % 3 == 2) begin
                cfg_word[CFG_POOL_SETPOINT] = {noise[31:16], pick_extreme_temp()};
                cfg_word[CFG_DIFF_ON]       = {noise[15:0], pick_extreme_temp()};
                cfg_word[CFG_DIFF_OFF]      = {noise[23:8], pick_extreme_temp()};
            end else begin
                pool_i = RST_SETPOINT + int'($urandom_range(0, 400)) - 200;
                cfg_word[CFG_POOL_SETPOINT] = {noise[31:16], pool_i[15:0]};
                thr = int'($urandom_range(0, 300));
                cfg_word[CFG_DIFF_ON]       = {noise[15:0], thr[15:0]};
                thr = int'($urandom_range(0, 300)) - 100;
                cfg_word[CFG_DIFF_OFF]      = {noise[23:8], thr[15:0]};
            end

            case (ph % 4)
                0: begin
                    cfg_word[CFG_MIN_ON_MS]  = RST_MIN_ON_MS;
                    cfg_word[CFG_MIN_OFF_MS] = RST_MIN_OFF_MS;
                    cfg_word[CFG_MAX_ON_MS]  = RST_MAX_ON_MS;
                    step_max = 250000;
                end
                1: begin
                    cfg_word[CFG_MIN_ON_MS]  = $urandom_range(0, 3000);
                    cfg_word[CFG_MIN_OFF_MS] = $urandom_range(0, 3000);
                    cfg_word[CFG_MAX_ON_MS]  = $urandom_range(0, 10000);
                    step_max = 1500;
                end
                2: begin
                    cfg_word[CFG_MIN_ON_MS]  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    cfg_word[CFG_MIN_OFF_MS] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    cfg_word[CFG_MAX_ON_MS]  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    step_max = 2000;
                end
                default: begin
                    cfg_word[CFG_MIN_ON_MS]  = $urandom();
                    cfg_word[CFG_MIN_OFF_MS] = $urandom();
                    cfg_word[CFG_MAX_ON_MS]  = $urandom();
                    step_max = $urandom();
                end
            endcase

            for (int k = 0; k < 7; k++) write_register(k[CFG_IDX_BITS-1:0], cfg_word[k]);
            write_register(CFG_IDX_SPARE, $urandom());

            for (int n = 0; n < PHASE_BEATS; n++) begin
                // Halfway through each phase the sender holds off until all results are in.
                if (n == PHASE_BEATS / 2) drain_results();

                if ($urandom_range(0, 9) == 0 || ph % 3 == 2 && $urandom_range(0, 3) == 0) begin
                    pool = TEMP_BITS'($urandom());
                    coll = TEMP_BITS'($urandom());
                end else begin
                    // Aim near the setpoint and near one of the two thresholds.
                    pool_i = int'(setpoint_q) + int'($urandom_range(0, 400)) - 200;
                    thr    = $urandom_range(0, 1) ? int'(diff_on_q) : int'(diff_off_q);
                    coll_i = pool_i + thr + int'($urandom_range(0, 40)) - 20;
                    pool   = pool_i[TEMP_BITS-1:0];
                    coll   = coll_i[TEMP_BITS-1:0];
                end

                if ($urandom_range(0, 49) == 0) now = $urandom();
                else now = now + $urandom_range(0, step_max);

                send_sample(pool, coll, now, 1'b0, '0);

                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    idle_gap($urandom_range(0, 1) ? $urandom_range(1, 8) : 0);
                end else begin
                    burst_left--;
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[differential_pump_controller_core] OK");
        end else begin
            $display("[differential_pump_controller_core] ERROR");
        end
        $finish;
    end

endmodule
